>>> design/isort_pkg.sv
// Shared types and constants for the insertion sorter.
package isort_pkg;

  // Store depth and the widths that follow from it.
  localparam int MAX_ITEMS = 64;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(MAX_ITEMS);
  localparam logic [CNT_W-1:0] FILL_ONE = CNT_W'(1);

  // One input beat.
  typedef struct packed {
    logic signed [31:0] value;
    logic               block_end;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               final_result;
    logic               dropped_some;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             insert;
    logic             emit;
    logic             final_result;
    logic             dropped_some;
    logic [CNT_W-1:0] fill;
  } isort_cmd_t;

endpackage

>>> design/isort_ctrl.sv
// Controller: accepts beats, tracks fill count and overflow, sequences output.
module isort_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 block_end,
  output logic                 busy,
  output isort_pkg::isort_cmd_t cmd
);
  import isort_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             ovf_r, ovf_nxt;
  logic             accept;
  logic             has_room;

  assign busy     = (state_r == ST_EMIT);
  assign accept   = start && !busy;
  assign has_room = (fill_r < FILL_MAX);

  // Next-state logic. During output the fill count doubles as the remaining count.
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    ovf_nxt   = ovf_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (has_room) begin
            fill_nxt = fill_r + FILL_ONE;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (block_end) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        fill_nxt = fill_r - FILL_ONE;
        if (fill_r == FILL_ONE) begin
          state_nxt = ST_IDLE;
          ovf_nxt   = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Commands to the datapath.
  always_comb begin
    cmd.insert       = accept && has_room;
    cmd.emit         = busy;
    cmd.final_result = (fill_r == FILL_ONE);
    cmd.dropped_some = ovf_r;
    cmd.fill         = fill_r;
  end

endmodule

>>> design/isort_datapath.sv
// Datapath: a row of sorted cells with parallel compare and shift, plus output register.
module isort_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  isort_pkg::isort_cmd_t cmd,
  input  logic signed [31:0]    new_value,
  output logic                  out_valid,
  output isort_pkg::out_item_t  out_item
);
  import isort_pkg::*;

  logic signed [31:0] cell_r   [MAX_ITEMS];
  logic signed [31:0] cell_nxt [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] gt;
  logic                 out_valid_r;
  out_item_t            out_item_r;

  // Each occupied cell flags whether it holds a value above the new one.
  always_comb begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      gt[i] = (CNT_W'(i) < cmd.fill) && (cell_r[i] > new_value);
    end
  end

  // Insert opens a gap by moving larger cells up; emit shifts all cells down.
  always_comb begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      cell_nxt[i] = cell_r[i];
      if (cmd.insert) begin
        if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
          cell_nxt[i] = cell_r[(i > 0) ? i - 1 : 0];
        end else if (gt[i] || (CNT_W'(i) == cmd.fill)) begin
          cell_nxt[i] = new_value;
        end
      end else if (cmd.emit && i < MAX_ITEMS - 1) begin
        cell_nxt[i] = cell_r[(i < MAX_ITEMS - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      cell_r[i] <= cell_nxt[i];
    end
  end

  // Output register: the bottom cell leaves on every emit cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item_r.sorted_value <= cell_r[0];
      out_item_r.final_result <= cmd.final_result;
      out_item_r.dropped_some <= cmd.dropped_some;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> design/insertion_sorter.sv
// Insertion sorter: one input beat per cycle while idle, then the sorted block, one beat a cycle.
// Each accepted value that fits is inserted in the same cycle by a parallel compare across all cells.
// After a block_end beat, busy stays high until all held values (at most 64) have been sent;
// each result appears in the cycle after its busy cycle, one per cycle; the receiver cannot stall them.
// Synchronous active-low reset empties the store and clears the overflow flag.
module insertion_sorter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  isort_pkg::in_item_t  in_item,
  output logic                 out_valid,
  output isort_pkg::out_item_t out_item
);
  import isort_pkg::*;

  isort_cmd_t cmd;

  isort_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .block_end (in_item.block_end),
    .busy      (busy),
    .cmd       (cmd)
  );

  isort_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .new_value (in_item.value),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Output only begins after an accepted beat that ends a block.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && in_item.block_end))
    else $error("busy rose without a block_end beat");

  // Every result beat comes from a cycle of output sequencing.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without output sequencing");

  // The final beat ends the block; earlier beats keep the block busy.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.final_result) |-> !busy)
    else $error("still busy after final beat");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.final_result) |-> busy)
    else $error("output stopped before final beat");

endmodule
